// ===== hw/rtl/packed_delta_value_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// packed delta value decoder assertion macros
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef PACKED_DELTA_VALUE_DECODER_DEFINES_SVH
`define PACKED_DELTA_VALUE_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define PDVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PDVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDVD_ASSERT(lbl, prop, msg)
`define PDVD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hw/rtl/pdvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdvd_pkg
// shared types and constants of the packed delta value decoder
// ----------------------------------------------------------------------------
package pdvd_pkg;

  localparam int MAX_COUNT_DEF = 64;
  localparam int MAX_RES = 4;

  typedef enum logic [1:0] {
    KIND_FIRST   = 2'd0,
    KIND_SECOND  = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_S_FIRST  = 4'd1,
    PH_S_SECOND = 4'd2,
    PH_S_BOTH   = 4'd3,
    PH_S_CTRL   = 4'd4,
    PH_S_ITEM   = 4'd5,
    PH_P_NIB    = 4'd6,
    PH_P_FIRST  = 4'd7,
    PH_P_SECOND = 4'd8,
    PH_P_DATA   = 4'd9
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  index;
    logic [15:0] value;
    logic [7:0]  first_count;
    logic [7:0]  second_count;
    logic        count_overflow;
    logic        last;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_vec_t;

  typedef struct packed {
    res_vec_t   res;
    logic [2:0] count;
  } batch_t;

endpackage

// ===== hw/rtl/pdvd_core.sv =====
// ----------------------------------------------------------------------------
// pdvd_core
// record state and per-item decode, producing a batch of up to four results
// ----------------------------------------------------------------------------
module pdvd_core import pdvd_pkg::*; #(
  parameter int MaxCount = MAX_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       fire,
  input  logic       op,
  input  logic [7:0] flags,
  input  logic [7:0] data_byte,
  output batch_t     batch
);

  localparam logic [7:0] MaxC = 8'(MaxCount);

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  fl;
    logic [7:0]  ft;
    logic [7:0]  st;
    logic [7:0]  fd;
    logic [7:0]  sd;
    logic [15:0] rv;
    logic [7:0]  cb;
    logic [3:0]  cl;
    logic        ha;
    logic [15:0] hb;
    logic [15:0] lsv;
    logic        ov;
    logic [2:0]  nn;
    logic        il;
  } st_t;

  st_t  s_r, s_nxt;
  logic mode_r;

  function automatic res_t mk(input kind_t k, input logic [7:0] i, input logic [15:0] v);
    res_t r;
    r = '0;
    r.kind = k;
    r.index = i[6:0];
    r.value = v;
    return r;
  endfunction

  function automatic void emit(inout batch_t b, input res_t r);
    if (b.count < 3'(MAX_RES)) begin
      b.res[b.count[1:0]] = r;
      b.count = b.count + 3'd1;
    end
  endfunction

  function automatic logic [7:0] clampc(inout st_t s, input logic [7:0] c);
    if (c > MaxC) begin
      s.ov = 1'b1;
      return MaxC;
    end
    return c;
  endfunction

  function automatic void fin_simple(inout st_t s, inout batch_t b);
    res_t r;
    r = mk(KIND_SUMMARY, 8'd0, 16'd0);
    r.first_count = s.ft;
    r.second_count = s.st;
    r.count_overflow = s.ov;
    r.last = 1'b1;
    emit(b, r);
    s.phase = PH_IDLE;
  endfunction

  function automatic void begin_simple(inout st_t s, inout batch_t b);
    s.fd = '0;
    s.sd = '0;
    s.rv = '0;
    s.ha = 1'b0;
    if ((s.ft == 8'd0) && (s.st == 8'd0)) fin_simple(s, b);
    else s.phase = PH_S_CTRL;
  endfunction

  function automatic void fin_packed(inout st_t s, inout batch_t b);
    logic [8:0] cnt;
    res_t       r;
    cnt = {1'b0, s.st} + {8'd0, s.fl[2]};
    if (cnt[0]) begin
      emit(b, mk(KIND_SECOND, cnt[7:0], s.lsv));
      cnt = cnt + 9'd1;
    end
    r = mk(KIND_SUMMARY, 8'd0, 16'd0);
    r.first_count = s.ft;
    r.second_count = cnt[7:0];
    r.count_overflow = s.ov;
    r.last = 1'b1;
    emit(b, r);
    s.phase = PH_IDLE;
  endfunction

  function automatic void enter_second(inout st_t s, inout batch_t b);
    s.sd = '0;
    if (s.fl[2]) begin
      emit(b, mk(KIND_SECOND, 8'd0, 16'd0));
      s.lsv = '0;
    end
    if (s.st == 8'd0) fin_packed(s, b);
  endfunction

  function automatic void begin_packed(inout st_t s, inout batch_t b);
    s.phase = PH_P_DATA;
    s.fd = '0;
    s.sd = '0;
    s.nn = '0;
    s.cb = '0;
    s.cl = '0;
    s.hb = '0;
    s.rv = '0;
    s.lsv = '0;
    if (s.ft == 8'd0) enter_second(s, b);
  endfunction

  function automatic logic [2:0] dnib(input st_t s, input logic lng);
    if (!lng) return 3'd2;
    return (s.fl[1:0] == 2'b11) ? 3'd4 : 3'd3;
  endfunction

  function automatic void simple_byte(inout st_t s, inout batch_t b, input logic [7:0] d);
    if (s.cb[0]) begin
      if (!s.ha) begin
        s.hb = {8'd0, d};
        s.ha = 1'b1;
        return;
      end
      s.rv = {s.hb[7:0], d};
      s.ha = 1'b0;
    end else begin
      s.rv = s.rv + {8'd0, d};
    end
    if (s.fd < s.ft) begin
      emit(b, mk(KIND_FIRST, s.fd, s.rv));
      s.fd = s.fd + 8'd1;
    end else begin
      emit(b, mk(KIND_SECOND, s.sd, s.rv));
      s.sd = s.sd + 8'd1;
    end
    s.cb = s.cb >> 1;
    s.cl = s.cl - 4'd1;
    if ((s.fd >= s.ft) && (s.sd >= s.st)) fin_simple(s, b);
    else if (s.cl == 4'd0) s.phase = PH_S_CTRL;
  endfunction

  function automatic void pnib(inout st_t s, inout batch_t b, input logic [3:0] n);
    logic        g;
    logic [7:0]  i;
    logic        lng;
    logic [15:0] v;
    g = !(s.fd < s.ft);
    i = g ? s.sd : s.fd;
    if (s.nn == 3'd0) begin
      if (i == 8'd0) begin
        lng = g ? s.fl[5] : s.fl[4];
        s.rv = '0;
      end else if (!s.fl[6]) begin
        lng = 1'b0;
      end else if (s.cl == 4'd0) begin
        s.cb = {4'd0, n};
        s.cl = 4'd3;
        s.il = n[0];
        s.nn = dnib(s, n[0]);
        s.hb = '0;
        return;
      end else begin
        s.cb = s.cb >> 1;
        s.cl = s.cl - 4'd1;
        lng = s.cb[0];
      end
      s.il = lng;
      s.nn = dnib(s, lng);
      s.hb = '0;
    end
    s.hb = {s.hb[11:0], n};
    s.nn = s.nn - 3'd1;
    if (s.nn != 3'd0) return;
    if (!s.il) v = {8'd0, s.hb[7:0]};
    else if (s.fl[1:0] == 2'b11) v = s.hb;
    else v = {{4{s.hb[11]}}, s.hb[11:0]};
    s.rv = s.rv + v;
    if (!g) begin
      emit(b, mk(KIND_FIRST, i, s.rv));
      s.fd = s.fd + 8'd1;
      if (s.fd >= s.ft) enter_second(s, b);
    end else begin
      emit(b, mk(KIND_SECOND, i + {7'd0, s.fl[2]}, s.rv));
      s.lsv = s.rv;
      s.sd = s.sd + 8'd1;
      if (s.sd >= s.st) fin_packed(s, b);
    end
  endfunction

  always_comb begin
    s_nxt = s_r;
    batch = '0;
    if (op == OP_START) begin
      s_nxt.fl = flags;
      s_nxt.ov = 1'b0;
      s_nxt.ft = '0;
      s_nxt.st = '0;
      s_nxt.ha = 1'b0;
      s_nxt.nn = '0;
      if (mode_r) begin
        case (flags[1:0])
          2'd0:    begin_packed(s_nxt, batch);
          2'd1:    s_nxt.phase = PH_P_NIB;
          default: s_nxt.phase = PH_P_FIRST;
        endcase
      end else if (flags[2]) s_nxt.phase = PH_S_BOTH;
      else if (flags[0]) s_nxt.phase = PH_S_FIRST;
      else if (flags[1]) s_nxt.phase = PH_S_SECOND;
      else begin_simple(s_nxt, batch);
    end else begin
      case (s_r.phase)
        PH_S_BOTH: begin
          s_nxt.ft = {4'd0, data_byte[3:0]};
          s_nxt.st = {4'd0, data_byte[7:4]};
          begin_simple(s_nxt, batch);
        end
        PH_S_FIRST: begin
          s_nxt.ft = clampc(s_nxt, data_byte);
          if (s_r.fl[1]) s_nxt.phase = PH_S_SECOND;
          else begin_simple(s_nxt, batch);
        end
        PH_S_SECOND: begin
          s_nxt.st = clampc(s_nxt, data_byte);
          begin_simple(s_nxt, batch);
        end
        PH_S_CTRL: begin
          s_nxt.cb = data_byte;
          s_nxt.cl = 4'd8;
          s_nxt.phase = PH_S_ITEM;
        end
        PH_S_ITEM: simple_byte(s_nxt, batch, data_byte);
        PH_P_NIB: begin
          s_nxt.ft = clampc(s_nxt, {4'd0, data_byte[3:0]});
          s_nxt.st = clampc(s_nxt, {4'd0, data_byte[7:4]});
          begin_packed(s_nxt, batch);
        end
        PH_P_FIRST: begin
          s_nxt.ft = clampc(s_nxt, data_byte);
          s_nxt.phase = PH_P_SECOND;
        end
        PH_P_SECOND: begin
          s_nxt.st = clampc(s_nxt, data_byte);
          begin_packed(s_nxt, batch);
        end
        PH_P_DATA: begin
          pnib(s_nxt, batch, data_byte[7:4]);
          if (s_nxt.phase == PH_P_DATA) pnib(s_nxt, batch, data_byte[3:0]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      mode_r <= 1'b0;
    end else begin
      if (cfg_wr_en) mode_r <= cfg_wr_data;
      if (fire) s_r <= s_nxt;
    end
  end

endmodule

// ===== hw/rtl/pdvd_outbuf.sv =====
// ----------------------------------------------------------------------------
// pdvd_outbuf
// result register holding one batch, shifted out one item a cycle if out_ready
// ----------------------------------------------------------------------------
`include "packed_delta_value_decoder_defines.svh"
module pdvd_outbuf import pdvd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  batch_t batch,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  res_vec_t   q_r;
  logic [2:0] n_r;
  logic       pop, load;

  assign out_valid = (n_r != 3'd0);
  assign out_res = q_r[0];
  assign pop = out_valid && out_ready;
  assign in_ready = (n_r == 3'd0) || ((n_r == 3'd1) && out_ready);
  assign load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else if (load) begin
      n_r <= batch.count;
    end else if (pop) begin
      n_r <= n_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= batch.res;
    end else if (pop) begin
      q_r <= {q_r[MAX_RES-1], q_r[MAX_RES-1:1]};
    end
  end

  `PDVD_ASSERT(a_cnt_range, n_r <= 3'(MAX_RES), "result count out of range")
  `PDVD_ASSERT(a_hold, (n_r > 3'd1) && !out_ready |=> n_r == $past(n_r), "batch lost")
  `PDVD_ASSERT(a_last_tail, out_valid && out_res.last |-> n_r == 3'd1, "last not at tail")

endmodule

// ===== hw/rtl/packed_delta_value_decoder.sv =====
// ----------------------------------------------------------------------------
// packed_delta_value_decoder
// decodes one record of two groups of 16-bit values from a byte stream
// ----------------------------------------------------------------------------
// in_ carries one item a cycle: in_tuser is the operation (0 start, 1 data),
// in_tdata holds the flags and the data byte. cfg_wr_en/cfg_wr_data set the
// packed mode register, sampled on each start item.
// out_ carries results: value, summary and padding items, tlast on the summary.
// An item is decoded in the cycle it is accepted and its results sit in the
// result register from the next cycle.
// Throughput is one item a cycle while each item yields at most one result
// and out_tready is high; an item that yields more holds in_tready low while
// the result register drains them one a cycle while out_tready is high.
// Reset (rst_n low, synchronous) returns to idle, mode simple, no results.
// When the receiver stalls, the held results stay and in_tready is low
// while any of them is waiting.
// ----------------------------------------------------------------------------
module packed_delta_value_decoder import pdvd_pkg::*; #(
  parameter int MaxCount = MAX_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // flags[7:0], data_byte[15:8]
  input  logic        in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // index, value, first_count, second_count, count_overflow
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast
);

  batch_t batch;
  res_t   res;
  logic   fire;

  assign fire = in_tvalid && in_tready;

  pdvd_core #(.MaxCount(MaxCount)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fire       (fire),
    .op         (in_tuser),
    .flags      (in_tdata[7:0]),
    .data_byte  (in_tdata[15:8]),
    .batch      (batch)
  );

  pdvd_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .batch    (batch),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {res.count_overflow, res.second_count, res.first_count,
                      res.value, res.index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
